FILE: sv/kebs_pkg.sv
// ---------------------------------------------------------------------------
// kebs_pkg
// Shared types, constants and tables for the Kepler bisection solver.
// ---------------------------------------------------------------------------
package kebs_pkg;

    localparam int MAX_ITERATIONS = 32;
    localparam int CORDIC_STEPS   = 30;
    localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
    localparam int STEP_W         = $clog2(CORDIC_STEPS + 1);

    // Q28 angles, carried in 34 bits signed
    localparam int ANG_W = 34;
    localparam logic signed [ANG_W-1:0] PI_Q28         = 34'sd843314857;
    localparam logic signed [ANG_W-1:0] TAU_Q28        = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q28    = 34'sd421657428;
    localparam logic signed [ANG_W-1:0] QUARTER_PI_Q28 = 34'sd210828714;

    // CORDIC datapath, Q30
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // register map
    localparam logic [0:0] REG_ITERATIONS = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SINE_START,
        ST_SINE_WAIT,
        ST_MULT,
        ST_UPDATE,
        ST_DONE
    } kebs_state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } kebs_cordic_ctl_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        begin
            case (idx)
                5'd0:  v = 34'sh03243F6A8;
                5'd1:  v = 34'sh01DAC6705;
                5'd2:  v = 34'sh00FADBAFC;
                5'd3:  v = 34'sh007F56EA6;
                5'd4:  v = 34'sh003FEAB76;
                5'd5:  v = 34'sh001FFD55B;
                5'd6:  v = 34'sh000FFFAAA;
                5'd7:  v = 34'sh0007FFF55;
                5'd8:  v = 34'sh0003FFFEA;
                5'd9:  v = 34'sh0001FFFFD;
                5'd10: v = 34'sh0000FFFFF;
                5'd11: v = 34'sh00007FFFF;
                5'd12: v = 34'sh00003FFFF;
                5'd13: v = 34'sh00001FFFF;
                5'd14: v = 34'sh00000FFFF;
                5'd15: v = 34'sh000007FFF;
                5'd16: v = 34'sh000003FFF;
                5'd17: v = 34'sh000001FFF;
                5'd18: v = 34'sh000000FFF;
                5'd19: v = 34'sh0000007FF;
                5'd20: v = 34'sh0000003FF;
                5'd21: v = 34'sh0000001FF;
                5'd22: v = 34'sh0000000FF;
                5'd23: v = 34'sh00000007F;
                5'd24: v = 34'sh00000003F;
                5'd25: v = 34'sh00000001F;
                5'd26: v = 34'sh00000000F;
                5'd27: v = 34'sh000000008;
                5'd28: v = 34'sh000000004;
                5'd29: v = 34'sh000000002;
                5'd30: v = 34'sh000000001;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: sv/kebs_cordic.sv
// ---------------------------------------------------------------------------
// kebs_cordic
// Iterative rotation-mode CORDIC: sine of a Q28 angle in [-pi, pi], Q30 out.
// ---------------------------------------------------------------------------
module kebs_cordic
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [kebs_pkg::ANG_W-1:0]   angle,
    output logic                                done,
    output logic signed [kebs_pkg::CW-1:0]      sine
);
    import kebs_pkg::*;

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [STEP_W-1:0]    i_reg, i_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic signed [ANG_W-1:0] folded;
    logic signed [CW-1:0] xs, ys;

    always_comb
    begin
        if (angle > HALF_PI_Q28)
            folded = PI_Q28 - angle;
        else if (angle < -HALF_PI_Q28)
            folded = -PI_Q28 - angle;
        else
            folded = angle;
    end

    // one micro-rotation per cycle
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = CORDIC_GAIN_Q30;
            y_next    = '0;
            z_next    = CW'(folded <<< 2);
            i_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[CW-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_q30(i_reg[4:0]);
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_q30(i_reg[4:0]);
            end
            i_next = i_reg + 1'b1;
            if (i_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done = done_reg;
    assign sine = y_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("start did not launch");

endmodule

FILE: sv/kepler_equation_bisection_solver.sv
// ---------------------------------------------------------------------------
// kepler_equation_bisection_solver
// Bisection solve of M = E - e*sin(E) with a single iterative CORDIC.
// ---------------------------------------------------------------------------
//  channel | signals                                      | direction
//  in      | in_valid, in_stall, mean_anomaly, eccentricity | item in
//  out     | out_valid, out_stall, eccentric_anomaly      | item out
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata/pready | register
//
//  Each item runs N bisection iterations, N = iterations (saturated to 32);
//  the CORDIC (one rotation/cycle) dominates. Reduction mod 2*pi: input*4
//  lies within just over +-5*2*pi, so it is a short compare-and-add/subtract
//  walk, one step a cycle.
//  Reset: iterations = 28, FSM idle, no result held.
//  Stalls: in_stall is high from acceptance until the result is loaded into
//  the output register; a finished item then waits in ST_DONE until the
//  previous result has been taken.
// ---------------------------------------------------------------------------
module kepler_equation_bisection_solver
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] mean_anomaly,
    input  logic [23:0] eccentricity,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [30:0] eccentric_anomaly,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kebs_pkg::*;

    kebs_state_t state_reg, state_next;

    logic [5:0]              iter_cfg_reg;
    logic [ITER_W-1:0]       n_reg, n_next, k_reg, k_next;
    logic signed [ANG_W-1:0] m_reg, m_next, e_reg, e_next, step_reg, step_next;
    logic [23:0]             ecc_reg, ecc_next;
    logic                    neg_reg, neg_next;
    logic signed [57:0]      prod_reg;
    logic signed [ANG_W-1:0] m1;
    logic signed [30:0]      res_reg, res_next;
    logic                    ov_reg, ov_next;
    logic                    cstart, cdone;
    logic signed [CW-1:0]    sine;

    // config port
    assign pready = 1'b1;
    assign prdata = {26'd0, iter_cfg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iter_cfg_reg <= 6'd28;
        else if (psel && penable && pwrite && paddr[2] == REG_ITERATIONS
                 && paddr[1:0] == 2'b00)
            iter_cfg_reg <= pwdata[5:0];
    end

    kebs_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cstart),
        .angle (e_reg),
        .done  (cdone),
        .sine  (sine)
    );

    // floor shift of the Q54 product down to Q28
    assign m1 = e_reg - ANG_W'(prod_reg >>> 26);

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        e_next     = e_reg;
        step_next  = step_reg;
        ecc_next   = ecc_reg;
        neg_next   = neg_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        cstart     = 1'b0;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    m_next     = ANG_W'(mean_anomaly) <<< 2;
                    ecc_next   = eccentricity;
                    n_next     = (iter_cfg_reg > 6'(MAX_ITERATIONS))
                                 ? ITER_W'(MAX_ITERATIONS) : ITER_W'(iter_cfg_reg);
                    k_next     = '0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (m_reg < 0)
                    m_next = m_reg + TAU_Q28;
                else if (m_reg >= TAU_Q28)
                    m_next = m_reg - TAU_Q28;
                else
                begin
                    neg_next  = m_reg > PI_Q28;
                    if (m_reg > PI_Q28)
                        m_next = TAU_Q28 - m_reg;
                    e_next    = HALF_PI_Q28;
                    step_next = QUARTER_PI_Q28;
                    k_next    = '0;
                    state_next = ST_SINE_START;
                end
            end
            ST_SINE_START:
            begin
                if (k_reg == n_reg)
                    state_next = ST_DONE;
                else
                begin
                    cstart     = 1'b1;
                    state_next = ST_SINE_WAIT;
                end
            end
            ST_SINE_WAIT:
            begin
                if (cdone)
                    state_next = ST_MULT;
            end
            ST_MULT:
                state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (m_reg > m1)
                    e_next = e_reg + step_reg;
                else
                    e_next = e_reg - step_reg;
                step_next  = step_reg >>> 1;
                k_next     = k_reg + 1'b1;
                state_next = ST_SINE_START;
            end
            ST_DONE:
            begin
                // load only once the previous result has left
                if (!ov_next)
                begin
                    ov_next    = 1'b1;
                    res_next   = 31'(neg_reg ? -e_reg : e_reg);
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            k_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        e_reg    <= e_next;
        step_reg <= step_next;
        ecc_reg  <= ecc_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
        // sine is Q30 within +-2^30, times 24-bit unsigned
        prod_reg <= 58'(sine) * $signed({1'b0, ecc_reg});
    end

    assign in_stall          = (state_reg != ST_IDLE);
    assign out_valid         = ov_reg;
    assign eccentric_anomaly = res_reg;

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= n_reg) else $error("iteration count overran");
    a_one_solve: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == ST_REDUCE)
        else $error("accepted item not started");
    a_cordic_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cdone |-> state_reg == ST_SINE_WAIT) else $error("stray sine");
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(eccentric_anomaly))
        else $error("result dropped");

endmodule
